/* design/pan_tilt_orientation_quaternion_defines.svh */
// assertion helpers for the pan/tilt orientation block
`ifndef PAN_TILT_ORIENTATION_QUATERNION_DEFINES_SVH
`define PAN_TILT_ORIENTATION_QUATERNION_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PTO_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define PTO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PTO_ASSERT_IMPL(lbl, ante, cons, msg)
`define PTO_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* design/pto_pkg.sv */
package pto_pkg;

  localparam int ANGLE_W = 16;
  localparam int P_W     = ANGLE_W + 1;
  localparam int R_W     = 15;
  localparam int T_W     = 14;
  localparam int FRAC_W  = 30;
  localparam int X_W     = 30;
  localparam int H_W     = 31;
  localparam int SC_W    = H_W + 1;
  localparam int U_W     = 28;
  localparam int XRCP_W  = 29;
  localparam int PM_W    = U_W + XRCP_W;
  localparam int SQ_W    = 2 * X_W;
  localparam int RCP_W   = 32;
  localparam int PROD_W  = 2 * SC_W - 1;
  localparam int MAG_W   = 61;
  localparam int Q15_W   = 16;

  localparam logic [H_W-1:0]    ONE_Q30  = 31'h4000_0000;
  localparam logic [FRAC_W-1:0] HALF_Q30 = 30'h2000_0000;

  // angle reduction, hundredths of a degree
  localparam logic [P_W-1:0] TURN_P     = 17'd72000;
  localparam logic [P_W-1:0] QTR_P      = 17'd18000;
  localparam logic [P_W-1:0] HALF_P     = 17'd36000;
  localparam logic [P_W-1:0] THREEQ_P   = 17'd54000;
  localparam logic [R_W-1:0] QTR_R      = 15'd18000;
  localparam logic [R_W-1:0] EIGHTH_R   = 15'd9000;

  // t * pi / 36000 in Q30, split as t*93701 + round(t*23426 / 36000)
  localparam logic [X_W-1:0]    X_BASE   = 30'd93701;
  localparam logic [U_W-1:0]    X_REM    = 28'd23426;
  localparam logic [U_W-1:0]    X_RND    = 28'd18000;
  localparam int                X_RCP_SH = 44;
  localparam logic [XRCP_W-1:0] X_RCP    =
    XRCP_W'(((64'd1 << X_RCP_SH) + 64'd35999) / 64'd36000);

  // exact reciprocals for the horner divisors, numerator below 2^31
  localparam logic [RCP_W-1:0] RCP_72 = RCP_W'(((64'd1 << 38) + 64'd71) / 64'd72);
  localparam logic [RCP_W-1:0] RCP_42 = RCP_W'(((64'd1 << 37) + 64'd41) / 64'd42);
  localparam logic [RCP_W-1:0] RCP_20 = RCP_W'(((64'd1 << 36) + 64'd19) / 64'd20);
  localparam logic [RCP_W-1:0] RCP_6  = RCP_W'(((64'd1 << 34) + 64'd5) / 64'd6);
  localparam logic [RCP_W-1:0] RCP_1  = RCP_W'(64'd1 << 31);
  localparam logic [RCP_W-1:0] RCP_90 = RCP_W'(((64'd1 << 38) + 64'd89) / 64'd90);
  localparam logic [RCP_W-1:0] RCP_56 = RCP_W'(((64'd1 << 37) + 64'd55) / 64'd56);
  localparam logic [RCP_W-1:0] RCP_30 = RCP_W'(((64'd1 << 36) + 64'd29) / 64'd30);
  localparam logic [RCP_W-1:0] RCP_12 = RCP_W'(((64'd1 << 35) + 64'd11) / 64'd12);
  localparam logic [RCP_W-1:0] RCP_2  = RCP_W'(((64'd1 << 32) + 64'd1) / 64'd2);

  typedef struct packed {
    logic [5:0]       half;
    logic [RCP_W-1:0] recip;
    logic [5:0]       shift;
  } pto_coef_t;

  typedef enum logic [1:0] {
    QUAD_FIRST  = 2'd0,
    QUAD_SECOND = 2'd1,
    QUAD_THIRD  = 2'd2,
    QUAD_FOURTH = 2'd3
  } pto_quad_t;

  typedef struct packed {
    logic [X_W-1:0] x;
    logic           mirror;
    pto_quad_t      quad;
  } pto_tag_t;

  localparam int CHAIN_LEN   = 5;
  localparam int CELL_STAGES = 4;
  localparam int FRONT_LAT   = 7;
  localparam int HSC_LAT     = FRONT_LAT + CHAIN_LEN * CELL_STAGES + 1;

  // last sine step divides by one and takes x instead of x^2: it forms 1 - x*h
  localparam pto_coef_t SIN_COEF [CHAIN_LEN] = '{
    '{half: 6'd36, recip: RCP_72, shift: 6'd38},
    '{half: 6'd21, recip: RCP_42, shift: 6'd37},
    '{half: 6'd10, recip: RCP_20, shift: 6'd36},
    '{half: 6'd3,  recip: RCP_6,  shift: 6'd34},
    '{half: 6'd0,  recip: RCP_1,  shift: 6'd31}
  };

  localparam pto_coef_t COS_COEF [CHAIN_LEN] = '{
    '{half: 6'd45, recip: RCP_90, shift: 6'd38},
    '{half: 6'd28, recip: RCP_56, shift: 6'd37},
    '{half: 6'd15, recip: RCP_30, shift: 6'd36},
    '{half: 6'd6,  recip: RCP_12, shift: 6'd35},
    '{half: 6'd1,  recip: RCP_2,  shift: 6'd32}
  };

  localparam int                OUT_SH  = 45;
  localparam logic [MAG_W-1:0]  OUT_RND = MAG_W'(1) << (OUT_SH - 1);
  localparam logic [MAG_W-1:0]  QMAX    = MAG_W'(32767);
  localparam logic [Q15_W-1:0]  Q15_MIN = 16'h8000;

endpackage

/* design/pto_cell.sv */
module pto_cell
  import pto_pkg::*;
(
  input  logic           clk,
  input  logic           en,
  input  pto_coef_t      coef,
  input  logic [X_W-1:0] mul_i,
  input  logic [H_W-1:0] h_i,
  input  pto_tag_t       tag_i,
  output logic [X_W-1:0] mul_o,
  output logic [H_W-1:0] h_o,
  output pto_tag_t       tag_o
);

  localparam int P1_W = X_W + H_W;
  localparam int P2_W = H_W + RCP_W;

  logic [P1_W-1:0] p1_r, p1_nxt;
  logic [H_W-1:0]  v_r, v_nxt;
  logic [P2_W-1:0] p2_r, p2_nxt;
  logic [H_W-1:0]  h_r, h_nxt;
  logic [P2_W-1:0] quo;

  logic [X_W-1:0] mul_r [CELL_STAGES];
  pto_tag_t       tag_r [CELL_STAGES];

  // one horner step: h_out = 1 - round(round(mul*h) / d)
  always_comb begin
    p1_nxt = P1_W'(mul_i) * P1_W'(h_i);
    v_nxt  = H_W'((p1_r + P1_W'(HALF_Q30)) >> FRAC_W) + H_W'(coef.half);
    p2_nxt = P2_W'(v_r) * P2_W'(coef.recip);
    quo    = p2_r >> coef.shift;
    h_nxt  = ONE_Q30 - quo[H_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r <= p1_nxt;
      v_r  <= v_nxt;
      p2_r <= p2_nxt;
      h_r  <= h_nxt;
      mul_r[0] <= mul_i;
      tag_r[0] <= tag_i;
      for (int i = 1; i < CELL_STAGES; i++) begin
        mul_r[i] <= mul_r[i-1];
        tag_r[i] <= tag_r[i-1];
      end
    end
  end

  assign mul_o = mul_r[CELL_STAGES-1];
  assign tag_o = tag_r[CELL_STAGES-1];
  assign h_o   = h_r;

endmodule

/* design/pto_halfsc.sv */
module pto_halfsc
  import pto_pkg::*;
(
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [ANGLE_W-1:0] angle_i,
  output logic signed [SC_W-1:0]   sin_o,
  output logic signed [SC_W-1:0]   cos_o
);

  // front end: reduction and conversion to radians
  logic [P_W-1:0]  p;
  pto_quad_t       quad_nxt, quad0_r;
  logic [R_W-1:0]  r_nxt, r0_r;
  logic            mir_nxt;
  logic [T_W-1:0]  t_nxt, t1_r, t2_r, t3_r;
  pto_tag_t        tag1_r, tag2_r, tag3_r, tag4_r, tag5_r, tag6_r;
  logic [U_W-1:0]  u_nxt, u2_r;
  logic [PM_W-1:0] pm_nxt, pm3_r;
  logic [X_W-1:0]  x_nxt;
  logic [SQ_W-1:0] sq_nxt, sq5_r;
  logic [X_W-1:0]  x2_nxt, x2_r;

  always_comb begin
    p = angle_i[ANGLE_W-1] ? ({1'b1, angle_i} + TURN_P) : {1'b0, angle_i};
    if (p >= THREEQ_P) begin
      quad_nxt = QUAD_FOURTH;
      r_nxt    = R_W'(p - THREEQ_P);
    end else if (p >= HALF_P) begin
      quad_nxt = QUAD_THIRD;
      r_nxt    = R_W'(p - HALF_P);
    end else if (p >= QTR_P) begin
      quad_nxt = QUAD_SECOND;
      r_nxt    = R_W'(p - QTR_P);
    end else begin
      quad_nxt = QUAD_FIRST;
      r_nxt    = R_W'(p);
    end
    // upper half of the quadrant folds back, sine and cosine trade places
    mir_nxt = (r0_r > EIGHTH_R);
    t_nxt   = mir_nxt ? T_W'(QTR_R - r0_r) : T_W'(r0_r);
    u_nxt   = U_W'(t1_r) * X_REM + X_RND;
    pm_nxt  = PM_W'(u2_r) * PM_W'(X_RCP);
    x_nxt   = X_W'(t3_r) * X_BASE + X_W'(pm3_r >> X_RCP_SH);
    sq_nxt  = SQ_W'(tag4_r.x) * SQ_W'(tag4_r.x);
    x2_nxt  = X_W'((sq5_r + SQ_W'(HALF_Q30)) >> FRAC_W);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quad0_r <= quad_nxt;
      r0_r    <= r_nxt;
      t1_r    <= t_nxt;
      tag1_r  <= '{x: '0, mirror: mir_nxt, quad: quad0_r};
      u2_r    <= u_nxt;
      t2_r    <= t1_r;
      tag2_r  <= tag1_r;
      pm3_r   <= pm_nxt;
      t3_r    <= t2_r;
      tag3_r  <= tag2_r;
      tag4_r  <= '{x: x_nxt, mirror: tag3_r.mirror, quad: tag3_r.quad};
      sq5_r   <= sq_nxt;
      tag5_r  <= tag4_r;
      x2_r    <= x2_nxt;
      tag6_r  <= tag5_r;
    end
  end

  // two rows of horner cells
  logic [X_W-1:0] s_mul [CHAIN_LEN+1];
  logic [H_W-1:0] s_h   [CHAIN_LEN+1];
  pto_tag_t       s_tag [CHAIN_LEN+1];
  logic [X_W-1:0] c_mul [CHAIN_LEN+1];
  logic [H_W-1:0] c_h   [CHAIN_LEN+1];
  pto_tag_t       c_tag [CHAIN_LEN+1];

  assign s_mul[0] = x2_r;
  assign s_h[0]   = ONE_Q30;
  assign s_tag[0] = tag6_r;
  assign c_mul[0] = x2_r;
  assign c_h[0]   = ONE_Q30;
  assign c_tag[0] = tag6_r;

  for (genvar i = 0; i < CHAIN_LEN; i++) begin : g_row
    localparam bit LAST = (i == CHAIN_LEN - 1);

    pto_cell u_sin (
      .clk   (clk),
      .en    (en),
      .coef  (SIN_COEF[i]),
      .mul_i (LAST ? s_tag[i].x : s_mul[i]),
      .h_i   (s_h[i]),
      .tag_i (s_tag[i]),
      .mul_o (s_mul[i+1]),
      .h_o   (s_h[i+1]),
      .tag_o (s_tag[i+1])
    );

    pto_cell u_cos (
      .clk   (clk),
      .en    (en),
      .coef  (COS_COEF[i]),
      .mul_i (c_mul[i]),
      .h_i   (c_h[i]),
      .tag_i (c_tag[i]),
      .mul_o (c_mul[i+1]),
      .h_o   (c_h[i+1]),
      .tag_o (c_tag[i+1])
    );
  end

  // back end: undo the fold and apply quadrant signs
  logic [H_W-1:0]         sv, cv, sm, cm;
  logic signed [SC_W-1:0] sp, cp, sin_nxt, cos_nxt, sin_r, cos_r;

  always_comb begin
    sv = ONE_Q30 - s_h[CHAIN_LEN];
    cv = c_h[CHAIN_LEN];
    sm = c_tag[CHAIN_LEN].mirror ? cv : sv;
    cm = c_tag[CHAIN_LEN].mirror ? sv : cv;
    sp = $signed({1'b0, sm});
    cp = $signed({1'b0, cm});
    sin_nxt = sp;
    cos_nxt = cp;
    unique case (c_tag[CHAIN_LEN].quad)
      QUAD_FIRST: begin
        sin_nxt = sp;
        cos_nxt = cp;
      end
      QUAD_SECOND: begin
        sin_nxt = cp;
        cos_nxt = -sp;
      end
      QUAD_THIRD: begin
        sin_nxt = -sp;
        cos_nxt = -cp;
      end
      QUAD_FOURTH: begin
        sin_nxt = -cp;
        cos_nxt = sp;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= sin_nxt;
      cos_r <= cos_nxt;
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

/* design/pan_tilt_orientation_quaternion.sv */
// throughput: one request per cycle; the sine/cosine cell rows and the product stage
// are fully pipelined and the whole pipeline holds while a waiting result is stalled
// reset: synchronous, active low; clears the pipeline valid flags and out_valid only
`include "pan_tilt_orientation_quaternion_defines.svh"

module pan_tilt_orientation_quaternion
  import pto_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [ANGLE_W-1:0] in_pan_angle,
  input  logic signed [ANGLE_W-1:0] in_tilt_angle,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [Q15_W-2:0]          out_quat_w,
  output logic signed [Q15_W-1:0]   out_quat_x,
  output logic signed [Q15_W-1:0]   out_quat_y,
  output logic signed [Q15_W-1:0]   out_quat_z
);

  localparam int PIPE_DEPTH = HSC_LAT + 2;

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } pto_mag_t;

  function automatic logic [MAG_W-1:0] mag_of(logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] a;
    a = v[PROD_W-1] ? -v : v;
    mag_of = a[MAG_W-1:0];
  endfunction

  // round half away from zero and limit to +-32767
  function automatic logic [Q15_W-1:0] to_q15(pto_mag_t v);
    logic [MAG_W-1:0] rnd;
    logic [Q15_W-1:0] m;
    rnd = (v.mag + OUT_RND) >> OUT_SH;
    m = (rnd > QMAX) ? QMAX[Q15_W-1:0] : rnd[Q15_W-1:0];
    to_q15 = v.neg ? -m : m;
  endfunction

  logic adv;
  logic [PIPE_DEPTH-1:0] vld_r, vld_nxt;
  logic out_valid_r;

  // whole pipeline moves unless the result register holds a stalled result
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;
  assign vld_nxt  = {vld_r[PIPE_DEPTH-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= vld_nxt;
      out_valid_r <= vld_r[PIPE_DEPTH-1];
    end
  end

  logic signed [SC_W-1:0] pan_sin, pan_cos, tilt_sin, tilt_cos;

  pto_halfsc u_pan (
    .clk     (clk),
    .en      (adv),
    .angle_i (in_pan_angle),
    .sin_o   (pan_sin),
    .cos_o   (pan_cos)
  );

  pto_halfsc u_tilt (
    .clk     (clk),
    .en      (adv),
    .angle_i (in_tilt_angle),
    .sin_o   (tilt_sin),
    .cos_o   (tilt_cos)
  );

  // products in Q60; cs is c1*s2, y is its negative
  logic signed [PROD_W-1:0] w_nxt, x_nxt, cs_nxt, z_nxt;
  logic signed [PROD_W-1:0] w_r, x_r, cs_r, z_r;
  logic                     flip;
  pto_mag_t                 mw_nxt, mx_nxt, my_nxt, mz_nxt;
  pto_mag_t                 mw_r, mx_r, my_r, mz_r;
  logic [Q15_W-1:0]         qw, qx, qy, qz;
  logic [Q15_W-2:0]         quat_w_r;
  logic [Q15_W-1:0]         quat_x_r, quat_y_r, quat_z_r;

  always_comb begin
    w_nxt  = PROD_W'(pan_cos) * PROD_W'(tilt_cos);
    x_nxt  = PROD_W'(pan_sin) * PROD_W'(tilt_sin);
    cs_nxt = PROD_W'(pan_cos) * PROD_W'(tilt_sin);
    z_nxt  = PROD_W'(pan_sin) * PROD_W'(tilt_cos);
    flip   = w_r[PROD_W-1];
    mw_nxt = '{neg: 1'b0, mag: mag_of(w_r)};
    mx_nxt = '{neg: x_r[PROD_W-1] ^ flip, mag: mag_of(x_r)};
    my_nxt = '{neg: (!cs_r[PROD_W-1] && (cs_r != '0)) ^ flip, mag: mag_of(cs_r)};
    mz_nxt = '{neg: z_r[PROD_W-1] ^ flip, mag: mag_of(z_r)};
    qw = to_q15(mw_r);
    qx = to_q15(mx_r);
    qy = to_q15(my_r);
    qz = to_q15(mz_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      w_r      <= w_nxt;
      x_r      <= x_nxt;
      cs_r     <= cs_nxt;
      z_r      <= z_nxt;
      mw_r     <= mw_nxt;
      mx_r     <= mx_nxt;
      my_r     <= my_nxt;
      mz_r     <= mz_nxt;
      quat_w_r <= qw[Q15_W-2:0];
      quat_x_r <= qx;
      quat_y_r <= qy;
      quat_z_r <= qz;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_quat_w = quat_w_r;
  assign out_quat_x = quat_x_r;
  assign out_quat_y = quat_y_r;
  assign out_quat_z = quat_z_r;

  `PTO_ASSERT_IMPL(a_no_neg_full_scale, out_valid_r, (quat_x_r != Q15_MIN) && (quat_y_r != Q15_MIN) && (quat_z_r != Q15_MIN), "output part at negative full scale")
  `PTO_ASSERT_NEXT(a_pipe_holds, out_valid_r && out_stall, $stable(vld_r) && out_valid_r, "pipeline moved under a stalled result")
  `PTO_ASSERT_IMPL(a_result_has_source, $rose(out_valid_r), $past(vld_r[PIPE_DEPTH-1]), "result without an item in the last stage")

endmodule

/* bench/testbench.sv */
`timescale 1ns / 100ps

module testbench;

  localparam longint unsigned Q30_ONE   = 64'd1 << 30;
  localparam longint unsigned Q30_HALF  = 64'd1 << 29;
  localparam longint unsigned PI_Q30    = 64'd3373259426;
  localparam longint unsigned Q15_LIMIT = 64'd32767;
  localparam int FULL_TURN    = 72000;
  localparam int QUARTER_TURN = 18000;
  localparam int EIGHTH_TURN  = 9000;
  localparam int RANDOM_ITEMS = 730;
  localparam int CYCLE_LIMIT  = 400000;

  localparam int DIRECTED_ITEMS = 21;
  localparam int DIRECTED_PAN [DIRECTED_ITEMS] = '{
    0, 18000, 0, -18000, 0, 18000, -18000, 32767, -32768, 32767, 9000,
    9001, 8999, 27000, 30000, 0, 17999, -1, 1, -32768, 12345
  };
  localparam int DIRECTED_TILT [DIRECTED_ITEMS] = '{
    0, 0, 18000, 0, -18000, 18000, -18000, 0, -32768, -32768, 9000,
    -9001, 27000, -27000, 0, 30000, 1, -17999, 1, 0, -23456
  };

  typedef struct {
    logic [14:0]        w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_t;

  class orientation_check;
    quat_t expected_quats[$];
    int    mismatches;

    function longint unsigned mul_q30(longint unsigned a, longint unsigned b);
      return (a * b + Q30_HALF) >> 30;
    endfunction

    function longint unsigned div_round(longint unsigned v, longint unsigned d);
      return (v + d / 2) / d;
    endfunction

    function longint unsigned sin_poly(longint unsigned x);
      longint unsigned x2, h;
      x2 = mul_q30(x, x);
      h = Q30_ONE - div_round(x2, 72);
      h = Q30_ONE - div_round(mul_q30(x2, h), 42);
      h = Q30_ONE - div_round(mul_q30(x2, h), 20);
      h = Q30_ONE - div_round(mul_q30(x2, h), 6);
      return mul_q30(x, h);
    endfunction

    function longint unsigned cos_poly(longint unsigned x);
      longint unsigned x2, h;
      x2 = mul_q30(x, x);
      h = Q30_ONE - div_round(x2, 90);
      h = Q30_ONE - div_round(mul_q30(x2, h), 56);
      h = Q30_ONE - div_round(mul_q30(x2, h), 30);
      h = Q30_ONE - div_round(mul_q30(x2, h), 12);
      h = Q30_ONE - div_round(mul_q30(x2, h), 2);
      return h;
    endfunction

    // sine and cosine of half the angle, signed q30
    function void half_sin_cos(input logic signed [15:0] angle,
                               output longint s, output longint c);
      int                  p, r, t;
      longint unsigned     xq, sv, cv, sr, cr;
      pto_pkg::pto_quad_t  quad;
      bit                  mirror;
      p = (int'(angle) + FULL_TURN) % FULL_TURN;
      quad = pto_pkg::pto_quad_t'(p / QUARTER_TURN);
      r = p % QUARTER_TURN;
      mirror = (r > EIGHTH_TURN);
      t = mirror ? QUARTER_TURN - r : r;
      xq = div_round(longint'(t) * PI_Q30, 36000);
      sv = sin_poly(xq);
      cv = cos_poly(xq);
      sr = mirror ? cv : sv;
      cr = mirror ? sv : cv;
      case (quad)
        pto_pkg::QUAD_FIRST: begin
          s = longint'(sr);
          c = longint'(cr);
        end
        pto_pkg::QUAD_SECOND: begin
          s = longint'(cr);
          c = -longint'(sr);
        end
        pto_pkg::QUAD_THIRD: begin
          s = -longint'(sr);
          c = -longint'(cr);
        end
        default: begin
          s = -longint'(cr);
          c = longint'(sr);
        end
      endcase
    endfunction

    // q60 to q15, rounded by magnitude and held inside +-1
    function logic [15:0] to_q15(longint v);
      longint unsigned mag;
      mag = (v < 0) ? -v : v;
      mag = (mag + (64'd1 << 44)) >> 45;
      if (mag > Q15_LIMIT) mag = Q15_LIMIT;
      return (v < 0) ? -mag[15:0] : mag[15:0];
    endfunction

    function quat_t predict_quat(logic signed [15:0] pan, logic signed [15:0] tilt);
      longint      s1, c1, s2, c2, w, x, y, z;
      logic [15:0] w16;
      quat_t       q;
      half_sin_cos(pan, s1, c1);
      half_sin_cos(tilt, s2, c2);
      w = c1 * c2;
      x = s1 * s2;
      y = -(c1 * s2);
      z = s1 * c2;
      // keep the scalar part non-negative; zero is left alone
      if (w < 0) begin
        w = -w;
        x = -x;
        y = -y;
        z = -z;
      end
      w16 = to_q15(w);
      q.w = w16[14:0];
      q.x = to_q15(x);
      q.y = to_q15(y);
      q.z = to_q15(z);
      return q;
    endfunction

    function void note_angles(logic signed [15:0] pan, logic signed [15:0] tilt);
      expected_quats.push_back(predict_quat(pan, tilt));
    endfunction

    function void check_field(string name, logic signed [15:0] want,
                              logic signed [15:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_quat(logic [14:0] w, logic signed [15:0] x,
                             logic signed [15:0] y, logic signed [15:0] z);
      quat_t q;
      if (expected_quats.size() == 0) begin
        $display("%0t: result with no request waiting, expected none, actual %0d %0d %0d %0d",
                 $time, w, x, y, z);
        mismatches++;
        return;
      end
      q = expected_quats.pop_front();
      check_field("quat_w", {1'b0, q.w}, {1'b0, w});
      check_field("quat_x", q.x, x);
      check_field("quat_y", q.y, y);
      check_field("quat_z", q.z, z);
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] in_pan_angle;
  logic signed [15:0] in_tilt_angle;
  logic               out_valid;
  logic               out_stall;
  logic [14:0]        out_quat_w;
  logic signed [15:0] out_quat_x;
  logic signed [15:0] out_quat_y;
  logic signed [15:0] out_quat_z;

  orientation_check orient_check = new();
  int               cycle_count = 0;

  pan_tilt_orientation_quaternion dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_pan_angle  (in_pan_angle),
    .in_tilt_angle (in_tilt_angle),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_quat_w    (out_quat_w),
    .out_quat_x    (out_quat_x),
    .out_quat_y    (out_quat_y),
    .out_quat_z    (out_quat_z)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // values seen here are the ones from before the edge
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      orient_check.note_angles(in_pan_angle, in_tilt_angle);
    if (rst_n && out_valid && !out_stall)
      orient_check.check_quat(out_quat_w, out_quat_x, out_quat_y, out_quat_z);
  end

  function automatic logic signed [15:0] random_angle();
    case ($urandom_range(0, 9))
      0, 1: return 16'($urandom);
      2: begin
        case ($urandom_range(0, 7))
          0: return 16'sd18000;
          1: return -16'sd18000;
          2: return 16'sd9000;
          3: return -16'sd9000;
          4: return 16'sd0;
          5: return 16'sd32767;
          6: return -16'sd32768;
          default: return 16'sd9001;
        endcase
      end
      default: return 16'(int'($urandom_range(0, 36000)) - 18000);
    endcase
  endfunction

  task automatic send_angles(input logic signed [15:0] pan, input logic signed [15:0] tilt,
                             input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_pan_angle  <= pan;
    in_tilt_angle <= tilt;
    do @(posedge clk); while (in_stall);
  endtask

  // receiver: random stalls, a calm stretch now and then, one long hold-off
  initial begin
    int wait_cycles;
    int taken;
    bit calm;
    out_stall <= 1'b0;
    taken = 0;
    calm = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (taken % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      if (taken == 300) wait_cycles = 200;
      else if (calm) wait_cycles = 0;
      else wait_cycles = $urandom_range(0, 19);
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (out_valid !== 1'b1);
      taken++;
    end
  end

  initial begin
    int gap;
    bit eager;
    in_valid      <= 1'b0;
    in_pan_angle  <= '0;
    in_tilt_angle <= '0;
    rst_n         <= 1'b0;
    eager = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < DIRECTED_ITEMS; k++)
      send_angles(16'(DIRECTED_PAN[k]), 16'(DIRECTED_TILT[k]), $urandom_range(0, 19));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 50 == 0) eager = ($urandom_range(0, 3) == 0);
      // back to back requests around the long hold-off so the pipe fills up
      if (eager || (i >= 260 && i < 460)) gap = 0;
      else gap = $urandom_range(0, 19);
      send_angles(random_angle(), random_angle(), gap);
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (orient_check.expected_quats.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (orient_check.mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
